@@ design/crrs_pkg.sv @@
// Package with shared types and constants for the clip region rectangle subtractor.
package crrs_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int COORD_W = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_EXCLUDE = 2'd2,
        CMD_NONE    = 2'd3
    } command_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] r;
        logic signed [COORD_W-1:0] t;
        logic signed [COORD_W-1:0] l;
    } rect_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_EX_READ,
        ST_EX_WAIT,
        ST_EX_PIECE,
        ST_COPY_READ,
        ST_COPY_WAIT,
        ST_COPY_WRITE,
        ST_LIST_READ,
        ST_LIST_WAIT,
        ST_LIST_SEND,
        ST_EMPTY_SEND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_cmd;
        logic clear_count;
        logic push_add;
        logic start_walk;
        logic read_store;
        logic read_fresh;
        logic latch_entry;
        logic piece_step;
        logic copy_write;
        logic finish_copy;
        logic start_list;
        logic load_out;
        logic load_empty;
        logic step_list;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;
        logic piece_done;
        logic copy_done;
        logic list_done;
        logic count_zero;
    } dp_status_t;

endpackage

@@ design/crrs_datapath.sv @@
// Datapath: rectangle store, fresh list, intersection and piece generation, output register.
module crrs_datapath #(
    parameter int CAPACITY = crrs_pkg::CAPACITY_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crrs_pkg::dp_cmd_t      cmd,
    output crrs_pkg::dp_status_t   status,
    input  logic [1:0]             in_command,
    input  crrs_pkg::rect_t        in_rect,
    output crrs_pkg::command_t     command,
    output crrs_pkg::rect_t        out_rect,
    output logic                   out_present,
    output logic                   out_overflow,
    output logic                   out_last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    crrs_pkg::rect_t store_mem [CAPACITY];
    crrs_pkg::rect_t fresh_mem [CAPACITY];

    crrs_pkg::command_t command_reg;
    crrs_pkg::rect_t    given_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               ovf_reg, ovf_next;
    logic [2:0]         piece_reg, piece_next;
    crrs_pkg::rect_t    rd_reg;
    crrs_pkg::rect_t    cur_reg;
    crrs_pkg::rect_t    hit_box_reg;
    crrs_pkg::rect_t    out_reg;
    logic               present_reg, last_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic               rd_fresh;
    crrs_pkg::rect_t    isect;
    logic               isect_ok;
    logic signed [16:0] ext [4];
    logic [1:0]         piece_sel;
    crrs_pkg::rect_t    piece;
    logic               piece_ok;
    logic               push_en;
    crrs_pkg::rect_t    push_val;
    logic               fresh_we;
    logic               store_we;
    logic [IDX_W-1:0]   store_wa;
    crrs_pkg::rect_t    store_wd;

    assign command = command_reg;
    assign piece_sel = piece_reg[1:0] - 2'd1;

    always_comb
    begin
        isect.l = (cur_reg.l > given_reg.l) ? cur_reg.l : given_reg.l;
        isect.t = (cur_reg.t > given_reg.t) ? cur_reg.t : given_reg.t;
        isect.r = (cur_reg.r < given_reg.r) ? cur_reg.r : given_reg.r;
        isect.b = (cur_reg.b < given_reg.b) ? cur_reg.b : given_reg.b;
        isect_ok = (isect.l <= isect.r) && (isect.t <= isect.b);
    end

    // Pieces use 17-bit edges so a piece beyond the coordinate range is always invalid.
    always_comb
    begin
        ext[0] = $signed({hit_box_reg.t[15], hit_box_reg.t}) - 17'sd1;
        ext[1] = $signed({hit_box_reg.b[15], hit_box_reg.b}) + 17'sd1;
        ext[2] = $signed({hit_box_reg.l[15], hit_box_reg.l}) - 17'sd1;
        ext[3] = $signed({hit_box_reg.r[15], hit_box_reg.r}) + 17'sd1;
        piece = cur_reg;
        piece_ok = 1'b0;
        unique case (piece_sel)
            2'd0:
            begin
                piece.b = ext[0][15:0];
                piece_ok = ($signed({cur_reg.t[15], cur_reg.t}) <= ext[0]);
            end
            2'd1:
            begin
                piece.t = ext[1][15:0];
                piece_ok = (ext[1] <= $signed({cur_reg.b[15], cur_reg.b}));
            end
            2'd2:
            begin
                piece.r = ext[2][15:0];
                piece.b = hit_box_reg.b;
                piece_ok = ($signed({cur_reg.l[15], cur_reg.l}) <= ext[2])
                           && (cur_reg.t <= hit_box_reg.b);
            end
            default:
            begin
                piece.l = ext[3][15:0];
                piece.t = hit_box_reg.t;
                piece_ok = (ext[3] <= $signed({cur_reg.r[15], cur_reg.r}))
                           && (hit_box_reg.t <= cur_reg.b);
            end
        endcase
    end

    always_comb
    begin
        push_en = 1'b0;
        push_val = piece;
        if (cmd.piece_step)
        begin
            if (piece_reg == 3'd0)
            begin
                push_en = !isect_ok;
                push_val = cur_reg;
            end
            else
            begin
                push_en = piece_ok;
            end
        end
        fresh_we = push_en && (n_reg < CAP_CNT);
    end

    always_comb
    begin
        rd_fresh = cmd.read_fresh;
        rd_addr = idx_reg[IDX_W-1:0] - IDX_W'(1);
        if (cmd.read_fresh)
        begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
        store_we = 1'b0;
        store_wa = count_reg[IDX_W-1:0];
        store_wd = given_reg;
        if (cmd.push_add && (count_reg < CAP_CNT))
        begin
            store_we = 1'b1;
        end
        else if (cmd.copy_write)
        begin
            store_we = 1'b1;
            store_wa = idx_reg[IDX_W-1:0] - IDX_W'(1);
            store_wd = rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= store_wd;
        end
        if (fresh_we)
        begin
            fresh_mem[n_reg[IDX_W-1:0]] <= push_val;
        end
        if (cmd.read_store || cmd.read_fresh)
        begin
            rd_reg <= rd_fresh ? fresh_mem[rd_addr] : store_mem[rd_addr];
        end
        if (cmd.load_cmd)
        begin
            given_reg <= in_rect;
        end
        if (cmd.latch_entry)
        begin
            cur_reg <= rd_reg;
        end
        if (cmd.piece_step && piece_reg == 3'd0)
        begin
            hit_box_reg <= isect;
        end
        if (cmd.load_out)
        begin
            out_reg <= rd_reg;
        end
        else if (cmd.load_empty)
        begin
            out_reg <= '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        ovf_next = ovf_reg;
        piece_next = piece_reg;
        if (cmd.load_cmd)
        begin
            ovf_next = 1'b0;
        end
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        if (cmd.push_add)
        begin
            if (count_reg < CAP_CNT)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.start_walk)
        begin
            idx_next = count_reg;
            n_next = '0;
        end
        if (cmd.latch_entry)
        begin
            idx_next = idx_reg - CNT_W'(1);
            piece_next = 3'd0;
        end
        if (cmd.piece_step)
        begin
            if (push_en)
            begin
                if (n_reg < CAP_CNT)
                begin
                    n_next = n_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            if (piece_reg == 3'd0 && !isect_ok)
            begin
                piece_next = 3'd5;
            end
            else
            begin
                piece_next = piece_reg + 3'd1;
            end
        end
        if (cmd.finish_copy)
        begin
            idx_next = '0;
            count_next = n_reg;
        end
        if (cmd.read_fresh)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.start_list)
        begin
            idx_next = count_next;
        end
        if (cmd.step_list)
        begin
            idx_next = idx_reg - CNT_W'(1);
        end
    end

    // During the piece step, piece 0 tests intersection with cur_reg and pushes nothing
    // when there is a hit; the hit box is held for the four pieces that follow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= crrs_pkg::CMD_CLEAR;
            count_reg <= '0;
            idx_reg <= '0;
            n_reg <= '0;
            ovf_reg <= 1'b0;
            piece_reg <= '0;
            present_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_cmd)
            begin
                command_reg <= crrs_pkg::command_t'(in_command);
            end
            count_reg <= count_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
            ovf_reg <= ovf_next;
            piece_reg <= piece_next;
            if (cmd.load_out)
            begin
                present_reg <= 1'b1;
                last_reg <= (idx_reg == CNT_W'(1));
            end
            else if (cmd.load_empty)
            begin
                present_reg <= 1'b0;
                last_reg <= 1'b1;
            end
        end
    end

    assign status.walk_done = (idx_reg == '0);
    assign status.piece_done = (piece_reg == 3'd5);
    assign status.copy_done = (idx_reg == n_reg);
    assign status.list_done = (idx_reg == CNT_W'(1));
    assign status.count_zero = (count_reg == '0);

    assign out_rect = out_reg;
    assign out_present = present_reg;
    assign out_overflow = ovf_reg;
    assign out_last = last_reg;

endmodule

@@ design/crrs_ctrl.sv @@
// Controller state machine sequencing add, exclude walk, copy back and listing.
module crrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  crrs_pkg::command_t    command,
    input  logic [1:0]            in_command,
    input  crrs_pkg::dp_status_t  status,
    output crrs_pkg::dp_cmd_t     cmd
);

    crrs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crrs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crrs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority case (crrs_pkg::command_t'(in_command))
                        crrs_pkg::CMD_ADD:     state_next = crrs_pkg::ST_ADD;
                        crrs_pkg::CMD_EXCLUDE: state_next = crrs_pkg::ST_EX_READ;
                        default:               state_next = crrs_pkg::ST_ADD;
                    endcase
                end
            end
            crrs_pkg::ST_ADD:
            begin
                state_next = (command == crrs_pkg::CMD_ADD || !status.count_zero)
                             ? crrs_pkg::ST_LIST_READ : crrs_pkg::ST_EMPTY_SEND;
            end
            crrs_pkg::ST_EX_READ:
            begin
                state_next = status.walk_done ? crrs_pkg::ST_COPY_READ
                                              : crrs_pkg::ST_EX_WAIT;
            end
            crrs_pkg::ST_EX_WAIT:    state_next = crrs_pkg::ST_EX_PIECE;
            crrs_pkg::ST_EX_PIECE:
            begin
                if (status.piece_done)
                begin
                    state_next = crrs_pkg::ST_EX_READ;
                end
            end
            crrs_pkg::ST_COPY_READ:
            begin
                if (status.copy_done)
                begin
                    state_next = status.count_zero ? crrs_pkg::ST_EMPTY_SEND
                                                   : crrs_pkg::ST_LIST_READ;
                end
                else
                begin
                    state_next = crrs_pkg::ST_COPY_WAIT;
                end
            end
            crrs_pkg::ST_COPY_WAIT:  state_next = crrs_pkg::ST_COPY_WRITE;
            crrs_pkg::ST_COPY_WRITE: state_next = crrs_pkg::ST_COPY_READ;
            crrs_pkg::ST_LIST_READ:  state_next = crrs_pkg::ST_LIST_WAIT;
            crrs_pkg::ST_LIST_WAIT:  state_next = crrs_pkg::ST_LIST_SEND;
            crrs_pkg::ST_LIST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = status.list_done ? crrs_pkg::ST_IDLE
                                                  : crrs_pkg::ST_LIST_READ;
                end
            end
            crrs_pkg::ST_EMPTY_SEND:
            begin
                if (out_ready)
                begin
                    state_next = crrs_pkg::ST_IDLE;
                end
            end
            default:                 state_next = crrs_pkg::ST_IDLE;
        endcase
    end

    // The copy step reads fresh[idx] then writes store[idx]; the write address is idx-1
    // because the read step already advanced idx.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            crrs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_cmd = 1'b1;
                    cmd.clear_count = (crrs_pkg::command_t'(in_command)
                                       == crrs_pkg::CMD_CLEAR);
                    cmd.start_walk = (crrs_pkg::command_t'(in_command)
                                      == crrs_pkg::CMD_EXCLUDE);
                end
            end
            crrs_pkg::ST_ADD:
            begin
                cmd.push_add = (command == crrs_pkg::CMD_ADD);
                cmd.start_list = 1'b1;
            end
            crrs_pkg::ST_EX_READ:
            begin
                cmd.read_store = !status.walk_done;
                cmd.finish_copy = status.walk_done;
            end
            crrs_pkg::ST_EX_WAIT:    cmd.latch_entry = 1'b1;
            crrs_pkg::ST_EX_PIECE:   cmd.piece_step = !status.piece_done;
            crrs_pkg::ST_COPY_READ:
            begin
                cmd.read_fresh = !status.copy_done;
                cmd.start_list = status.copy_done;
            end
            crrs_pkg::ST_COPY_WAIT:  cmd = '0;
            crrs_pkg::ST_COPY_WRITE: cmd.copy_write = 1'b1;
            crrs_pkg::ST_LIST_READ:  cmd.read_store = 1'b1;
            crrs_pkg::ST_LIST_WAIT:  cmd.load_out = 1'b1;
            crrs_pkg::ST_LIST_SEND:
            begin
                out_valid = 1'b1;
                cmd.step_list = out_ready;
            end
            crrs_pkg::ST_EMPTY_SEND: out_valid = 1'b1;
            default:                 cmd = '0;
        endcase
        if (state_next == crrs_pkg::ST_EMPTY_SEND && state_reg != crrs_pkg::ST_EMPTY_SEND)
        begin
            cmd.load_empty = 1'b1;
        end
    end

endmodule

@@ design/clip_region_rect_subtract.sv @@
// Top level of the clip region rectangle subtractor.
//   channel   dir  contents
//   s_axis    in   command, rectangle to add or exclude
//   m_axis    out  listed rectangle with present, overflow and last
// One word is taken at a time. Clear or add passes through the add state; exclude walks every
// stored entry, keeping one that misses the rectangle and the pieces of one that meets it,
// then copies each kept result back to the store; then each stored word is read from the
// single-port store and listed. Reset empties the region.
// A stalled master side holds the word and the block until it is taken.
module clip_region_rect_subtract #(
    parameter int CAPACITY = crrs_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // command, rect_left, rect_top, rect_right, rect_bottom
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_left, out_top, out_right, out_bottom
    output logic [1:0]  m_axis_tuser,   // present, overflow
    output logic        m_axis_tlast
);

    crrs_pkg::dp_cmd_t    cmd;
    crrs_pkg::dp_status_t status;
    crrs_pkg::command_t   command;
    crrs_pkg::rect_t      in_rect;
    crrs_pkg::rect_t      out_rect;
    logic                 present;
    logic                 overflow;

    assign in_rect.l = s_axis_tdata[17:2];
    assign in_rect.t = s_axis_tdata[33:18];
    assign in_rect.r = s_axis_tdata[49:34];
    assign in_rect.b = s_axis_tdata[65:50];

    crrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .command    (command),
        .in_command (s_axis_tdata[1:0]),
        .status     (status),
        .cmd        (cmd)
    );

    crrs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_command   (s_axis_tdata[1:0]),
        .in_rect      (in_rect),
        .command      (command),
        .out_rect     (out_rect),
        .out_present  (present),
        .out_overflow (overflow),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {out_rect.b, out_rect.r, out_rect.t, out_rect.l};
    assign m_axis_tuser = {overflow, present};

endmodule
